### design/ssoc_pkg.sv
// ssoc_pkg: shared constants, opcodes, sequencer states and status struct
// for the sorted set overlap counter; depends on nothing
package ssoc_pkg;

  localparam int MAX_LEN  = 1024;
  localparam int ID_WIDTH = 32;
  localparam int ADDR_W   = $clog2(MAX_LEN);
  localparam int LEN_W    = $clog2(MAX_LEN + 1);
  localparam int COMMON_W = 11;
  localparam int UNION_W  = 12;

  typedef enum logic [1:0] {
    OP_APPEND_A = 2'd0,
    OP_APPEND_B = 2'd1,
    OP_COMPUTE  = 2'd2,
    OP_NONE     = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_C_RD,
    ST_C_CMP,
    ST_U_RD,
    ST_U_CMP,
    ST_SA_RD,
    ST_SA_CMP,
    ST_SB_RD,
    ST_SB_CMP,
    ST_DONE
  } merge_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } merge_stat_t;

endpackage

### design/ssoc_ram.sv
// ssoc_ram: generic single write port, single read port memory with
// registered read data; depends on nothing
module ssoc_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/ssoc_merge.sv
// ssoc_merge: two-pointer merge sequencer around one shared comparator,
// an intersection pass followed by a union pass; depends on ssoc_pkg
module ssoc_merge (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ssoc_pkg::LEN_W-1:0]     len_a,
  input  logic [ssoc_pkg::LEN_W-1:0]     len_b,
  input  logic [ssoc_pkg::ID_WIDTH-1:0]  data_a,
  input  logic [ssoc_pkg::ID_WIDTH-1:0]  data_b,
  output logic [ssoc_pkg::ADDR_W-1:0]    addr_a,
  output logic [ssoc_pkg::ADDR_W-1:0]    addr_b,
  output logic [ssoc_pkg::COMMON_W-1:0]  common,
  output logic [ssoc_pkg::UNION_W-1:0]   uni,
  output ssoc_pkg::merge_stat_t          stat
);

  ssoc_pkg::merge_state_t state, state_next;

  logic [ssoc_pkg::LEN_W-1:0]    pa, pa_next;
  logic [ssoc_pkg::LEN_W-1:0]    pb, pb_next;
  logic [ssoc_pkg::COMMON_W-1:0] common_next;
  logic [ssoc_pkg::UNION_W-1:0]  uni_next;
  logic [ssoc_pkg::ID_WIDTH-1:0] run_val, run_val_next;
  logic                          also_a, also_a_next;

  logic [ssoc_pkg::ID_WIDTH-1:0] cmp_x, cmp_y;
  logic                          cmp_eq, cmp_lt, cmp_gt;
  logic                          has_a, has_b;

  assign has_a = pa < len_a;
  assign has_b = pb < len_b;
  assign addr_a = pa[ssoc_pkg::ADDR_W-1:0];
  assign addr_b = pb[ssoc_pkg::ADDR_W-1:0];

  // shared comparator
  always_comb begin
    case (state)
      ssoc_pkg::ST_SA_CMP: begin
        cmp_x = data_a;
        cmp_y = run_val;
      end
      ssoc_pkg::ST_SB_CMP: begin
        cmp_x = data_b;
        cmp_y = run_val;
      end
      default: begin
        cmp_x = data_a;
        cmp_y = data_b;
      end
    endcase
    cmp_eq = cmp_x == cmp_y;
    cmp_lt = cmp_x < cmp_y;
    cmp_gt = !cmp_eq && !cmp_lt;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ssoc_pkg::ST_IDLE: begin
        if (start) begin
          state_next = ssoc_pkg::ST_C_RD;
        end
      end
      ssoc_pkg::ST_C_RD: state_next = ssoc_pkg::ST_C_CMP;
      ssoc_pkg::ST_C_CMP: begin
        state_next = (has_a && has_b) ? ssoc_pkg::ST_C_RD : ssoc_pkg::ST_U_RD;
      end
      ssoc_pkg::ST_U_RD: state_next = ssoc_pkg::ST_U_CMP;
      ssoc_pkg::ST_U_CMP: begin
        if (has_a && has_b) begin
          state_next = cmp_lt ? ssoc_pkg::ST_SA_RD : ssoc_pkg::ST_SB_RD;
        end else if (has_a) begin
          state_next = ssoc_pkg::ST_SA_RD;
        end else if (has_b) begin
          state_next = ssoc_pkg::ST_SB_RD;
        end else begin
          state_next = ssoc_pkg::ST_DONE;
        end
      end
      ssoc_pkg::ST_SA_RD: state_next = ssoc_pkg::ST_SA_CMP;
      ssoc_pkg::ST_SA_CMP: begin
        state_next = (has_a && cmp_eq) ? ssoc_pkg::ST_SA_RD : ssoc_pkg::ST_U_RD;
      end
      ssoc_pkg::ST_SB_RD: state_next = ssoc_pkg::ST_SB_CMP;
      ssoc_pkg::ST_SB_CMP: begin
        if (has_b && cmp_eq) begin
          state_next = ssoc_pkg::ST_SB_RD;
        end else if (also_a) begin
          state_next = ssoc_pkg::ST_SA_RD;
        end else begin
          state_next = ssoc_pkg::ST_U_RD;
        end
      end
      ssoc_pkg::ST_DONE: state_next = ssoc_pkg::ST_IDLE;
      default: state_next = ssoc_pkg::ST_IDLE;
    endcase
  end

  // datapath and status
  always_comb begin
    pa_next      = pa;
    pb_next      = pb;
    common_next  = common;
    uni_next     = uni;
    run_val_next = run_val;
    also_a_next  = also_a;
    stat.busy    = 1'b1;
    stat.done    = 1'b0;
    case (state)
      ssoc_pkg::ST_IDLE: begin
        stat.busy = 1'b0;
        if (start) begin
          pa_next     = '0;
          pb_next     = '0;
          common_next = '0;
          uni_next    = '0;
        end
      end
      ssoc_pkg::ST_C_CMP: begin
        if (has_a && has_b) begin
          if (cmp_eq) begin
            common_next = common + ssoc_pkg::COMMON_W'(1);
            pa_next     = pa + ssoc_pkg::LEN_W'(1);
            pb_next     = pb + ssoc_pkg::LEN_W'(1);
          end else if (cmp_lt) begin
            pa_next = pa + ssoc_pkg::LEN_W'(1);
          end else begin
            pb_next = pb + ssoc_pkg::LEN_W'(1);
          end
        end else begin
          pa_next = '0;
          pb_next = '0;
        end
      end
      ssoc_pkg::ST_U_CMP: begin
        if (has_a || has_b) begin
          uni_next = uni + ssoc_pkg::UNION_W'(1);
        end
        also_a_next = 1'b0;
        if (has_a && has_b) begin
          if (cmp_gt) begin
            run_val_next = data_b;
            pb_next      = pb + ssoc_pkg::LEN_W'(1);
          end else if (cmp_lt) begin
            run_val_next = data_a;
            pa_next      = pa + ssoc_pkg::LEN_W'(1);
          end else begin
            run_val_next = data_a;
            pa_next      = pa + ssoc_pkg::LEN_W'(1);
            pb_next      = pb + ssoc_pkg::LEN_W'(1);
            also_a_next  = 1'b1;
          end
        end else if (has_a) begin
          run_val_next = data_a;
          pa_next      = pa + ssoc_pkg::LEN_W'(1);
        end else if (has_b) begin
          run_val_next = data_b;
          pb_next      = pb + ssoc_pkg::LEN_W'(1);
        end
      end
      ssoc_pkg::ST_SA_CMP: begin
        if (has_a && cmp_eq) begin
          pa_next = pa + ssoc_pkg::LEN_W'(1);
        end
      end
      ssoc_pkg::ST_SB_CMP: begin
        if (has_b && cmp_eq) begin
          pb_next = pb + ssoc_pkg::LEN_W'(1);
        end
      end
      ssoc_pkg::ST_DONE: stat.done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssoc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
    pa      <= pa_next;
    pb      <= pb_next;
    common  <= common_next;
    uni     <= uni_next;
    run_val <= run_val_next;
    also_a  <= also_a_next;
  end

endmodule

### design/sorted_set_overlap_counter_core.sv
// sorted_set_overlap_counter_core: top level with list storage, lengths,
// overflow flag and result register; depends on ssoc_pkg, ssoc_ram, ssoc_merge
//
// Appends (opcode 0 to the first list, 1 to the second) are written straight
// into the list memory. A compute request (opcode 2) runs an intersection pass
// and then a union pass over both lists; every merge step has a read state for
// the registered memory read and a compare state for the shared comparator.
// The union pass also spends a step closing every run of equal values. A compute
// holds off requests until the sequencer is idle again, and its result is
// registered into the output when the sequencer reaches its done state.
// Appends are taken while a finished result waits; a further compute waits
// until that result is taken. Opcode 3 is accepted and ignored.
module sorted_set_overlap_counter_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     opcode,
  input  logic [31:0]                    vertex_id,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ssoc_pkg::COMMON_W-1:0]  common_count,
  output logic [ssoc_pkg::UNION_W-1:0]   union_count,
  output logic                           overflow
);

  logic [ssoc_pkg::LEN_W-1:0]    first_length;
  logic [ssoc_pkg::LEN_W-1:0]    second_length;
  logic                          overflow_seen;
  logic                          in_accept;
  logic                          op_a, op_b, op_c;
  logic                          room_a, room_b;
  logic [ssoc_pkg::ID_WIDTH-1:0] id;
  logic [ssoc_pkg::ADDR_W-1:0]   addr_a, addr_b;
  logic [ssoc_pkg::ID_WIDTH-1:0] data_a, data_b;
  logic [ssoc_pkg::COMMON_W-1:0] common;
  logic [ssoc_pkg::UNION_W-1:0]  uni;
  ssoc_pkg::merge_stat_t         stat;

  assign op_a   = opcode == ssoc_pkg::OP_APPEND_A;
  assign op_b   = opcode == ssoc_pkg::OP_APPEND_B;
  assign op_c   = opcode == ssoc_pkg::OP_COMPUTE;
  assign room_a = first_length < ssoc_pkg::LEN_W'(ssoc_pkg::MAX_LEN);
  assign room_b = second_length < ssoc_pkg::LEN_W'(ssoc_pkg::MAX_LEN);
  assign id     = ssoc_pkg::ID_WIDTH'(vertex_id);

  assign in_stall  = rst || stat.busy || (out_valid && op_c);
  assign in_accept = in_valid && !in_stall;

  ssoc_ram #(
    .WIDTH (ssoc_pkg::ID_WIDTH),
    .DEPTH (ssoc_pkg::MAX_LEN),
    .ADDR_W(ssoc_pkg::ADDR_W)
  ) u_ram_a (
    .clk  (clk),
    .we   (in_accept && op_a && room_a),
    .waddr(first_length[ssoc_pkg::ADDR_W-1:0]),
    .wdata(id),
    .raddr(addr_a),
    .rdata(data_a)
  );

  ssoc_ram #(
    .WIDTH (ssoc_pkg::ID_WIDTH),
    .DEPTH (ssoc_pkg::MAX_LEN),
    .ADDR_W(ssoc_pkg::ADDR_W)
  ) u_ram_b (
    .clk  (clk),
    .we   (in_accept && op_b && room_b),
    .waddr(second_length[ssoc_pkg::ADDR_W-1:0]),
    .wdata(id),
    .raddr(addr_b),
    .rdata(data_b)
  );

  ssoc_merge u_merge (
    .clk   (clk),
    .rst   (rst),
    .start (in_accept && op_c),
    .len_a (first_length),
    .len_b (second_length),
    .data_a(data_a),
    .data_b(data_b),
    .addr_a(addr_a),
    .addr_b(addr_b),
    .common(common),
    .uni   (uni),
    .stat  (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      first_length  <= '0;
      second_length <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (stat.done) begin
        first_length  <= '0;
        second_length <= '0;
        overflow_seen <= 1'b0;
        out_valid     <= 1'b1;
      end else begin
        if (out_valid && !out_stall) begin
          out_valid <= 1'b0;
        end
        if (in_accept && op_a) begin
          if (room_a) begin
            first_length <= first_length + ssoc_pkg::LEN_W'(1);
          end else begin
            overflow_seen <= 1'b1;
          end
        end
        if (in_accept && op_b) begin
          if (room_b) begin
            second_length <= second_length + ssoc_pkg::LEN_W'(1);
          end else begin
            overflow_seen <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      common_count <= common;
      union_count  <= uni;
      overflow     <= overflow_seen;
    end
  end

`ifndef NO_ASSERTIONS
  a_rise_after_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(stat.done))
    else $error("result shown without a finished merge");

  a_done_slot_free: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> !out_valid)
    else $error("merge finished while a result still waits");

  a_compute_starts: assert property (@(posedge clk) disable iff (rst)
    (in_accept && op_c) |=> stat.busy)
    else $error("compute request did not start the merge");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    (first_length <= ssoc_pkg::LEN_W'(ssoc_pkg::MAX_LEN)) &&
    (second_length <= ssoc_pkg::LEN_W'(ssoc_pkg::MAX_LEN)))
    else $error("list length beyond capacity");
`endif

endmodule

### tb/tb_sorted_set_overlap_counter_core.sv
`timescale 1ns / 1ps
// tb_sorted_set_overlap_counter_core: self-checking testbench that loads sorted and
// unsorted id lists, predicts the overlap and distinct counts and checks every result;
// depends on ssoc_pkg and sorted_set_overlap_counter_core
module tb_sorted_set_overlap_counter_core;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 600;
  localparam int PHASE_REQS   = 130;

  typedef struct {
    ssoc_pkg::opcode_t op;
    logic [31:0]       id;
  } request_t;

  typedef struct packed {
    logic [ssoc_pkg::COMMON_W-1:0] common_n;
    logic [ssoc_pkg::UNION_W-1:0]  distinct_n;
    logic                          dropped;
  } tally_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [1:0]                    opcode = ssoc_pkg::OP_NONE;
  logic [31:0]                   vertex_id = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [ssoc_pkg::COMMON_W-1:0] common_count;
  logic [ssoc_pkg::UNION_W-1:0]  union_count;
  logic                          overflow;

  request_t    req_fifo[$];
  tally_t      tally_fifo[$];
  request_t    drive_req;
  tally_t      want;

  logic [31:0] first_mem [ssoc_pkg::MAX_LEN];
  logic [31:0] second_mem[ssoc_pkg::MAX_LEN];
  int unsigned first_len = 0;
  int unsigned second_len = 0;
  bit          drop_seen = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_go = 1'b0;
  logic        hold_on = 1'b0;

  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned requests_queued = 0;
  int unsigned computes_taken = 0;
  int unsigned cycle_n = 0;

  sorted_set_overlap_counter_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .vertex_id    (vertex_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .common_count (common_count),
    .union_count  (union_count),
    .overflow     (overflow)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned pair_matches();
    int unsigned i, j, n;
    i = 0;
    j = 0;
    n = 0;
    while (i < first_len && j < second_len) begin
      if (first_mem[i] == second_mem[j]) begin
        n++;
        i++;
        j++;
      end else if (first_mem[i] > second_mem[j]) begin
        j++;
      end else begin
        i++;
      end
    end
    return n;
  endfunction

  function automatic int unsigned distinct_values();
    int unsigned i, j, n;
    logic [31:0] a, b;
    i = 0;
    j = 0;
    n = 0;
    while (i < first_len && j < second_len) begin
      a = first_mem[i];
      b = second_mem[j];
      if (b < a) begin
        while (j < second_len && second_mem[j] == b) j++;
      end else if (a < b) begin
        while (i < first_len && first_mem[i] == a) i++;
      end else begin
        while (j < second_len && second_mem[j] == a) j++;
        while (i < first_len && first_mem[i] == a) i++;
      end
      n++;
    end
    while (i < first_len) begin
      a = first_mem[i];
      while (i < first_len && first_mem[i] == a) i++;
      n++;
    end
    while (j < second_len) begin
      b = second_mem[j];
      while (j < second_len && second_mem[j] == b) j++;
      n++;
    end
    return n;
  endfunction

  function automatic void apply_request(ssoc_pkg::opcode_t op, logic [31:0] id);
    tally_t t;
    case (op)
      ssoc_pkg::OP_APPEND_A: begin
        if (first_len < ssoc_pkg::MAX_LEN) begin
          first_mem[first_len] = id;
          first_len++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      ssoc_pkg::OP_APPEND_B: begin
        if (second_len < ssoc_pkg::MAX_LEN) begin
          second_mem[second_len] = id;
          second_len++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      ssoc_pkg::OP_COMPUTE: begin
        t.common_n   = pair_matches();
        t.distinct_n = distinct_values();
        t.dropped    = drop_seen;
        tally_fifo   = {tally_fifo, t};
        first_len  = 0;
        second_len = 0;
        drop_seen  = 1'b0;
        computes_taken++;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_request(ssoc_pkg::opcode_t'(opcode), vertex_id);
      if (!in_valid || !in_stall) begin
        if (req_fifo.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drive_req = req_fifo.pop_front();
          in_valid  <= 1'b1;
          opcode    <= drive_req.op;
          vertex_id <= drive_req.id;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (tally_fifo.size() == 0) begin
          errors++;
          if (errors <= 40)
            $display("%0t: unexpected result, expected none, actual %0d %0d %0b",
                     $time, common_count, union_count, overflow);
        end else begin
          want = tally_fifo.pop_front();
          check_field("common_count", want.common_n, common_count);
          check_field("union_count", want.distinct_n, union_count);
          check_field("overflow", want.dropped, overflow);
        end
      end
      out_stall <= hold_on || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // long receiver hold-off
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_n, tally_fifo.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic queue_req(ssoc_pkg::opcode_t op, logic [31:0] id);
    request_t r;
    r.op = op;
    r.id = id;
    req_fifo = {req_fifo, r};
    if (op != ssoc_pkg::OP_NONE) requests_queued++;
  endtask

  task automatic wait_drained();
    while (req_fifo.size() != 0 || in_valid || tally_fifo.size() != 0) @(negedge clk);
  endtask

  // ascending lists drawn from one candidate walk, so values overlap and repeat
  task automatic queue_sorted_set(int unsigned max_cand);
    logic [31:0]     a_q[$];
    logic [31:0]     b_q[$];
    longint unsigned v;
    int unsigned     n_cand, a_pct, b_pct, dup_pct, step_max, reps, k;
    n_cand   = $urandom_range(0, max_cand);
    a_pct    = $urandom_range(20, 100);
    b_pct    = $urandom_range(20, 100);
    dup_pct  = $urandom_range(0, 30);
    step_max = ($urandom_range(0, 3) == 0) ? 32'h00FF_FFFF : $urandom_range(1, 4);
    case ($urandom_range(0, 3))
      0: v = 0;
      1: v = 64'hFFFF_FFFF - longint'(n_cand) * step_max;
      default: v = $urandom;
    endcase
    for (k = 0; k < n_cand && v <= 64'hFFFF_FFFF; k++) begin
      if ($urandom_range(1, 100) <= a_pct) begin
        reps = ($urandom_range(1, 100) <= dup_pct) ? $urandom_range(2, 3) : 1;
        repeat (reps) a_q = {a_q, v[31:0]};
      end
      if ($urandom_range(1, 100) <= b_pct) begin
        reps = ($urandom_range(1, 100) <= dup_pct) ? $urandom_range(2, 3) : 1;
        repeat (reps) b_q = {b_q, v[31:0]};
      end
      v += $urandom_range(1, step_max);
    end
    while (a_q.size() + b_q.size() > 0) begin
      if ($urandom_range(0, 19) == 0) queue_req(ssoc_pkg::OP_NONE, $urandom);
      if (b_q.size() == 0 || (a_q.size() != 0 && $urandom_range(0, 1) == 1))
        queue_req(ssoc_pkg::OP_APPEND_A, a_q.pop_front());
      else
        queue_req(ssoc_pkg::OP_APPEND_B, b_q.pop_front());
    end
    queue_req(ssoc_pkg::OP_COMPUTE, $urandom);
  endtask

  task automatic queue_unsorted_set();
    int unsigned n, k;
    n = $urandom_range(1, 10);
    for (k = 0; k < n; k++)
      queue_req($urandom_range(0, 1) ? ssoc_pkg::OP_APPEND_B : ssoc_pkg::OP_APPEND_A,
                $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom);
    queue_req(ssoc_pkg::OP_COMPUTE, $urandom);
  endtask

  task automatic run_random_phase(int unsigned send_pct, int unsigned recv_pct);
    int unsigned start, r;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    start = requests_queued;
    while (requests_queued - start < PHASE_REQS) begin
      r = $urandom_range(0, 99);
      if (r < 75) queue_sorted_set(12);
      else if (r < 80) queue_sorted_set(60);
      else if (r < 92) queue_unsorted_set();
      else if (r < 96) queue_req(ssoc_pkg::OP_COMPUTE, $urandom);
      else queue_req(ssoc_pkg::OP_NONE, $urandom);
    end
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty lists
    queue_req(ssoc_pkg::OP_COMPUTE, 32'hFFFF_FFFF);
    // matches at both ends of the id range, duplicates on each side
    queue_req(ssoc_pkg::OP_APPEND_A, 32'h0000_0000);
    queue_req(ssoc_pkg::OP_APPEND_B, 32'h0000_0000);
    queue_req(ssoc_pkg::OP_APPEND_A, 32'h0000_0000);
    queue_req(ssoc_pkg::OP_NONE, 32'hFFFF_FFFF);
    queue_req(ssoc_pkg::OP_APPEND_A, 32'h0000_0005);
    queue_req(ssoc_pkg::OP_APPEND_B, 32'h0000_0005);
    queue_req(ssoc_pkg::OP_APPEND_B, 32'h0000_0005);
    queue_req(ssoc_pkg::OP_APPEND_A, 32'hFFFF_FFFF);
    queue_req(ssoc_pkg::OP_APPEND_B, 32'hFFFF_FFFF);
    queue_req(ssoc_pkg::OP_COMPUTE, 32'h0000_0000);
    // one list empty
    queue_req(ssoc_pkg::OP_APPEND_A, 32'h0000_0001);
    queue_req(ssoc_pkg::OP_APPEND_A, 32'h0000_0002);
    queue_req(ssoc_pkg::OP_APPEND_A, 32'h0000_0003);
    queue_req(ssoc_pkg::OP_COMPUTE, 32'h5555_5555);
    queue_req(ssoc_pkg::OP_APPEND_B, 32'h8000_0000);
    queue_req(ssoc_pkg::OP_NONE, 32'h0000_0000);
    queue_req(ssoc_pkg::OP_COMPUTE, 32'hAAAA_AAAA);
    // unsorted lists
    queue_req(ssoc_pkg::OP_APPEND_A, 32'h0000_0009);
    queue_req(ssoc_pkg::OP_APPEND_A, 32'h0000_0003);
    queue_req(ssoc_pkg::OP_APPEND_A, 32'h0000_0009);
    queue_req(ssoc_pkg::OP_APPEND_B, 32'h0000_0003);
    queue_req(ssoc_pkg::OP_APPEND_B, 32'h0000_0009);
    queue_req(ssoc_pkg::OP_COMPUTE, 32'h0000_0000);
    queue_req(ssoc_pkg::OP_COMPUTE, 32'h0000_0000);
    wait_drained();

    run_random_phase(0, 0);
    run_random_phase(65, 0);
    run_random_phase(0, 65);
    run_random_phase(20, 20);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_go = 1'b1;
    repeat (8) queue_sorted_set(6);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d requests and %0d computes with %0d results checked",
             requests_queued, computes_taken, results_seen);
    $display("sorted, duplicate and unsorted lists under four idle mixes and a long output hold");
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### files.f
design/ssoc_pkg.sv
design/ssoc_ram.sv
design/ssoc_merge.sv
design/sorted_set_overlap_counter_core.sv
tb/tb_sorted_set_overlap_counter_core.sv
